/* sv/uifc_pkg.sv */
// Package: conversion codes, kinds and beat payload types for the converter.
`default_nettype none
package uifc_pkg;

    // conversion codes carried in the action field
    localparam logic [4:0] A_U8_U16  = 5'd0;
    localparam logic [4:0] A_U8_U32  = 5'd1;
    localparam logic [4:0] A_U8_U64  = 5'd2;
    localparam logic [4:0] A_U16_U32 = 5'd3;
    localparam logic [4:0] A_U16_U64 = 5'd4;
    localparam logic [4:0] A_U32_U64 = 5'd5;
    localparam logic [4:0] A_U64_U32 = 5'd6;
    localparam logic [4:0] A_U64_U16 = 5'd7;
    localparam logic [4:0] A_U64_U8  = 5'd8;
    localparam logic [4:0] A_U32_U16 = 5'd9;
    localparam logic [4:0] A_U32_U8  = 5'd10;
    localparam logic [4:0] A_U16_U8  = 5'd11;
    localparam logic [4:0] A_U8_F32  = 5'd12;
    localparam logic [4:0] A_U8_F64  = 5'd13;
    localparam logic [4:0] A_U16_F32 = 5'd14;
    localparam logic [4:0] A_U16_F64 = 5'd15;
    localparam logic [4:0] A_U32_F32 = 5'd16;
    localparam logic [4:0] A_U32_F64 = 5'd17;
    localparam logic [4:0] A_U64_F32 = 5'd18;
    localparam logic [4:0] A_U64_F64 = 5'd19;
    localparam logic [4:0] A_F64_U64 = 5'd20;
    localparam logic [4:0] A_F64_U32 = 5'd21;
    localparam logic [4:0] A_F64_U16 = 5'd22;
    localparam logic [4:0] A_F64_U8  = 5'd23;
    localparam logic [4:0] A_F32_U64 = 5'd24;
    localparam logic [4:0] A_F32_U32 = 5'd25;
    localparam logic [4:0] A_F32_U16 = 5'd26;
    localparam logic [4:0] A_F32_U8  = 5'd27;
    localparam logic [4:0] A_UNUSED  = 5'd31;

    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_INT  = 2'd1,
        K_I2F  = 2'd2,
        K_F2I  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        W_8  = 2'd0,
        W_16 = 2'd1,
        W_32 = 2'd2,
        W_64 = 2'd3
    } t_width;

    typedef struct packed {
        t_kind  kind;
        t_width src_w;
        t_width dst_w;
    } t_desc;

    typedef struct packed {
        logic [4:0]  action;
        logic [63:0] source_bits;
    } t_in;

    typedef struct packed {
        logic [63:0] result_bits;
        logic        range_flag;
    } t_out;

    function automatic t_desc decode(input logic [4:0] a);
        t_desc d;
        d = '{K_NONE, W_8, W_8};
        unique case (a)
            A_U8_U16:  d = '{K_INT, W_8,  W_16};
            A_U8_U32:  d = '{K_INT, W_8,  W_32};
            A_U8_U64:  d = '{K_INT, W_8,  W_64};
            A_U16_U32: d = '{K_INT, W_16, W_32};
            A_U16_U64: d = '{K_INT, W_16, W_64};
            A_U32_U64: d = '{K_INT, W_32, W_64};
            A_U64_U32: d = '{K_INT, W_64, W_32};
            A_U64_U16: d = '{K_INT, W_64, W_16};
            A_U64_U8:  d = '{K_INT, W_64, W_8};
            A_U32_U16: d = '{K_INT, W_32, W_16};
            A_U32_U8:  d = '{K_INT, W_32, W_8};
            A_U16_U8:  d = '{K_INT, W_16, W_8};
            A_U8_F32:  d = '{K_I2F, W_8,  W_32};
            A_U8_F64:  d = '{K_I2F, W_8,  W_64};
            A_U16_F32: d = '{K_I2F, W_16, W_32};
            A_U16_F64: d = '{K_I2F, W_16, W_64};
            A_U32_F32: d = '{K_I2F, W_32, W_32};
            A_U32_F64: d = '{K_I2F, W_32, W_64};
            A_U64_F32: d = '{K_I2F, W_64, W_32};
            A_U64_F64: d = '{K_I2F, W_64, W_64};
            A_F64_U64: d = '{K_F2I, W_64, W_64};
            A_F64_U32: d = '{K_F2I, W_64, W_32};
            A_F64_U16: d = '{K_F2I, W_64, W_16};
            A_F64_U8:  d = '{K_F2I, W_64, W_8};
            A_F32_U64: d = '{K_F2I, W_32, W_64};
            A_F32_U32: d = '{K_F2I, W_32, W_32};
            A_F32_U16: d = '{K_F2I, W_32, W_16};
            A_F32_U8:  d = '{K_F2I, W_32, W_8};
            default:   d = '{K_NONE, W_8, W_8};
        endcase
        return d;
    endfunction

    function automatic logic [63:0] wmask(input t_width w);
        logic [63:0] m;
        unique case (w)
            W_8:  m = 64'h0000_0000_0000_00FF;
            W_16: m = 64'h0000_0000_0000_FFFF;
            W_32: m = 64'h0000_0000_FFFF_FFFF;
            W_64: m = 64'hFFFF_FFFF_FFFF_FFFF;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

/* sv/unsigned_int_float_convert.sv */
// Each beat is registered at every stage; one beat per cycle unless the output stalls.
// Stage 1 decodes and masks, stage 2 finds the leading one or unpacks the float,
// stage 3 shifts, stage 4 rounds and packs. A stall holds every stage in place.
// Synchronous active-low reset clears the stage valid bits only.
// No stage iterates; every stage takes a new beat whenever the pipeline advances.
`default_nettype none
module unsigned_int_float_convert (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire uifc_pkg::t_in   i_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output uifc_pkg::t_out       o_data
);

    // Pipeline advances as a whole when the output is free.
    logic w_adv;
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;

    // ---------------- stage 1: decode, mask
    logic            r_v1;
    uifc_pkg::t_desc r_d1;
    logic [63:0]     r_src1;

    uifc_pkg::t_desc n_d1;
    assign n_d1 = uifc_pkg::decode(i_data.action);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
        end
        if (w_adv) begin
            r_d1   <= n_d1;
            r_src1 <= i_data.source_bits & uifc_pkg::wmask(n_d1.src_w);
        end
    end

    // ---------------- stage 2: leading one (int) / unpack (float)
    logic [5:0]  n_p2;
    logic        n_nz2;
    always_comb begin
        n_p2  = '0;
        n_nz2 = |r_src1;
        for (int i = 0; i < 64; i++) begin
            if (r_src1[i]) n_p2 = 6'(i);
        end
    end

    logic        w_f64;
    logic        n_neg2;
    logic [10:0] n_e2;
    logic [52:0] n_sig2;
    logic        n_emax2;
    logic        n_fz2;
    always_comb begin
        w_f64 = (r_d1.src_w == uifc_pkg::W_64);
        if (w_f64) begin
            n_neg2  = r_src1[63];
            n_e2    = r_src1[62:52];
            n_sig2  = {1'b1, r_src1[51:0]};
            n_emax2 = &r_src1[62:52];
            n_fz2   = ~|r_src1[51:0];
        end else begin
            n_neg2  = r_src1[31];
            n_e2    = {3'b000, r_src1[30:23]};
            n_sig2  = {1'b1, r_src1[22:0], 29'd0};
            n_emax2 = &r_src1[30:23];
            n_fz2   = ~|r_src1[22:0];
        end
    end

    logic            r_v2;
    uifc_pkg::t_desc r_d2;
    logic [63:0]     r_src2;
    logic [5:0]      r_p2;
    logic            r_nz2;
    logic            r_f64_2;
    logic            r_neg2;
    logic [10:0]     r_e2;
    logic            r_emax2;
    logic            r_fz2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v2 <= r_v1;
        end
        if (w_adv) begin
            r_d2    <= r_d1;
            r_src2  <= (r_d1.kind == uifc_pkg::K_F2I) ? {11'd0, n_sig2} : r_src1;
            r_p2    <= n_p2;
            r_nz2   <= n_nz2;
            r_f64_2 <= w_f64;
            r_neg2  <= n_neg2;
            r_e2    <= n_e2;
            r_emax2 <= n_emax2;
            r_fz2   <= n_fz2;
        end
    end

    // ---------------- stage 3: shift
    // Int to float: normalise so the leading one sits at bit 63.
    // Float to int: unbiased exponent ue, value = sig53 * 2^(ue-52).
    logic [63:0] n_norm3;
    logic [11:0] n_ue3;
    logic [63:0] n_fi3;
    logic        n_lt1;
    logic        n_big;
    logic [6:0]  w_dw;
    always_comb begin
        n_norm3 = r_src2 << (6'd63 - r_p2);
        n_ue3   = {1'b0, r_e2} - (r_f64_2 ? 12'd1023 : 12'd127);
        unique case (r_d2.dst_w)
            uifc_pkg::W_8:  w_dw = 7'd8;
            uifc_pkg::W_16: w_dw = 7'd16;
            uifc_pkg::W_32: w_dw = 7'd32;
            default:        w_dw = 7'd64;
        endcase
        n_lt1 = (r_e2 == 11'd0) || n_ue3[11];
        n_big = !n_ue3[11] && (n_ue3[10:0] >= {4'd0, w_dw});
        n_fi3 = '0;
        if (!n_lt1 && !n_big) begin
            if (n_ue3[5:0] <= 6'd52) begin
                n_fi3 = r_src2 >> (6'd52 - n_ue3[5:0]);
            end else begin
                n_fi3 = r_src2 << (n_ue3[5:0] - 6'd52);
            end
        end
    end

    logic            r_v3;
    uifc_pkg::t_desc r_d3;
    logic [63:0]     r_src3;
    logic [63:0]     r_norm3;
    logic [5:0]      r_p3;
    logic            r_nz3;
    logic [63:0]     r_fi3;
    logic            r_lt1;
    logic            r_big;
    logic            r_neg3;
    logic            r_emax3;
    logic            r_fz3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v3 <= r_v2;
        end
        if (w_adv) begin
            r_d3    <= r_d2;
            r_src3  <= r_src2;
            r_norm3 <= n_norm3;
            r_p3    <= r_p2;
            r_nz3   <= r_nz2;
            r_fi3   <= n_fi3;
            r_lt1   <= n_lt1;
            r_big   <= n_big;
            r_neg3  <= r_neg2;
            r_emax3 <= r_emax2;
            r_fz3   <= r_fz2;
        end
    end

    // ---------------- stage 4: round, pack, saturate
    logic [63:0] n_res;
    logic        n_flag;
    logic [24:0] w_s32;
    logic [53:0] w_s64;
    logic        w_up;
    logic [11:0] w_ex;
    always_comb begin
        n_res  = '0;
        n_flag = 1'b0;
        w_s32  = '0;
        w_s64  = '0;
        w_up   = 1'b0;
        w_ex   = '0;
        unique case (r_d3.kind)
            uifc_pkg::K_INT: begin
                n_res = r_src3 & uifc_pkg::wmask(r_d3.dst_w);
            end
            uifc_pkg::K_I2F: begin
                if (r_nz3) begin
                    if (r_d3.dst_w == uifc_pkg::W_32) begin
                        // keep 24 bits, guard at bit 39, sticky below
                        w_up  = r_norm3[39] && ((|r_norm3[38:0]) || r_norm3[40]);
                        w_s32 = {1'b0, r_norm3[63:40]} + {24'd0, w_up};
                        w_ex  = {6'd0, r_p3} + 12'd127 + {11'd0, w_s32[24]};
                        n_res = {32'd0, 1'b0, w_ex[7:0],
                                 w_s32[24] ? w_s32[23:1] : w_s32[22:0]};
                    end else begin
                        w_up  = r_norm3[10] && ((|r_norm3[9:0]) || r_norm3[11]);
                        w_s64 = {1'b0, r_norm3[63:11]} + {53'd0, w_up};
                        w_ex  = {6'd0, r_p3} + 12'd1023 + {11'd0, w_s64[53]};
                        n_res = {1'b0, w_ex[10:0],
                                 w_s64[53] ? w_s64[52:1] : w_s64[51:0]};
                    end
                end
            end
            uifc_pkg::K_F2I: begin
                if (r_emax3) begin
                    n_flag = 1'b1;
                    n_res  = (!r_fz3 || r_neg3) ? '0 : uifc_pkg::wmask(r_d3.dst_w);
                end else if (r_lt1) begin
                    n_res = '0;
                end else if (r_neg3) begin
                    n_flag = 1'b1;
                end else if (r_big) begin
                    n_flag = 1'b1;
                    n_res  = uifc_pkg::wmask(r_d3.dst_w);
                end else begin
                    n_res = r_fi3;
                end
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= r_v3;
        end
        if (w_adv) begin
            o_data.result_bits <= n_res;
            o_data.range_flag  <= n_flag;
        end
    end

endmodule
`default_nettype wire
